// File: hdl/wmbz_pkg.sv
// wmbz_pkg: shared constants, types and arithmetic helpers for the window map
// and bilinear zoom block; no dependencies
package wmbz_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_ZOOM    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int LVL_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W = 9;
  localparam int ZOOM_W  = 4;
  localparam int WM_W    = 15;
  localparam int SMP_W   = 16;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 3;
  localparam int NUM_W   = 24;
  localparam int RECIP_W = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int STEP_W  = 17;
  localparam int SUM_W   = 22;

  localparam logic [LVL_W-1:0] ROUND_TERM = 8'h80;
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(MAX_HEIGHT - 1);

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_MAX  = 3'd0,
    REG_COLOR_LOW   = 3'd1,
    REG_COLOR_HIGH  = 3'd2,
    REG_ZOOM        = 3'd3,
    REG_PLANE_WIDTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WM_W-1:0]    window_max;
    logic [LVL_W-1:0]   color_low;
    logic [LVL_W-1:0]   color_high;
    logic [ZOOM_W-1:0]  zoom;
    logic [WIDTH_W-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LVL_W-1:0] cur;
    logic [LVL_W-1:0] left;
    logic [LVL_W-1:0] up;
    logic [LVL_W-1:0] upper_left;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t data;
  } qpush_t;

  function automatic logic [ZOOM_W-1:0] clamp_zoom(input logic [ZOOM_W-1:0] z);
    logic [ZOOM_W-1:0] r;
    r = z;
    if (z == '0) r = ZOOM_W'(1);
    else if (z > ZOOM_W'(MAX_ZOOM)) r = ZOOM_W'(MAX_ZOOM);
    return r;
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    r = w;
    if (w == '0) r = WIDTH_W'(1);
    else if (w > WIDTH_W'(MAX_WIDTH)) r = WIDTH_W'(MAX_WIDTH);
    return r;
  endfunction

  // ceil(2^20 / z): exact truncating quotient for dividends below 2^17
  function automatic logic [RECIP_W-1:0] recip(input logic [ZOOM_W-1:0] z);
    logic [RECIP_W-1:0] r;
    unique case (z)
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd7:    r = 21'd149797;
      4'd8:    r = 21'd131072;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] interp_val(input logic [LVL_W-1:0] a,
                                                  input logic signed [STEP_W-1:0] step,
                                                  input logic [ZOOM_W-1:0] i);
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    prod = SUM_W'($signed({1'b0, i}) * step);
    sum  = $signed({6'd0, a, ROUND_TERM}) + prod;
    return sum[SUM_W-1] ? '0 : sum[2*LVL_W-1:LVL_W];
  endfunction

endpackage

// File: hdl/wmbz_if.sv
// wmbz_if: valid/ready channel interfaces for samples and zoomed pixels
// depends on wmbz_pkg
interface wmbz_in_if;
  import wmbz_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;
  logic             plane_start;
  modport source (output valid, sample, plane_start, input ready);
  modport sink   (input valid, sample, plane_start, output ready);
endinterface

interface wmbz_out_if;
  import wmbz_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [LVL_W-1:0]   pixel;
  logic               last_of_run;
  modport source (output valid, out_row, out_col, pixel, last_of_run, input ready);
  modport sink   (input valid, out_row, out_col, pixel, last_of_run, output ready);
endinterface

// File: hdl/wmbz_ram.sv
// wmbz_ram: generic single write, single read ram with registered read
// no dependencies
module wmbz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/wmbz_queue.sv
// wmbz_queue: short request queue between front and back
// depends on wmbz_pkg
module wmbz_queue (
  input  logic            clk,
  input  logic            rst,
  input  wmbz_pkg::qpush_t push,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output wmbz_pkg::qent_t head
);
  import wmbz_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qent_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push.data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PTR_W'(1);
      if (do_pop) rptr <= rptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + (PTR_W+1)'(1);
      else if (do_pop && !do_push) count <= count - (PTR_W+1)'(1);
    end
  end
endmodule

// File: hdl/wmbz_front.sv
// wmbz_front: sample intake, row/column tracking, level mapping by a
// bit-serial divider and line store access; depends on wmbz_pkg, wmbz_if, wmbz_ram
module wmbz_front (
  input  logic             clk,
  input  logic             rst,
  input  wmbz_pkg::cfg_t   cfg,
  wmbz_in_if.sink          samples,
  output wmbz_pkg::qpush_t push,
  input  logic             full
);
  import wmbz_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          state;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] c_q;
  logic [ROW_W-1:0] r_q;
  logic [LVL_W-1:0] left_lvl;
  logic [LVL_W-1:0] ul_lvl;
  logic             sat_lo;
  logic             sat_hi;
  logic             rev;
  logic [NUM_W-1:0] rem;
  logic [LVL_W-1:0] quo;
  logic [2:0]       k;

  logic             accept;
  logic             fire;
  logic [COL_W-1:0] c_start;
  logic [ROW_W-1:0] r_start;
  logic [LVL_W-1:0] d;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] shifted;
  logic [LVL_W-1:0] cur;
  logic [LVL_W-1:0] up;
  logic [WIDTH_W-1:0] c_inc;
  logic             rev_now;

  assign samples.ready = state == F_IDLE;
  assign accept = samples.valid && samples.ready;
  assign fire   = state == F_PUSH && !full;

  always_comb begin
    c_start = col;
    r_start = row;
    if (samples.plane_start) begin
      c_start = '0;
      r_start = '0;
    end else if ({1'b0, col} >= cfg.width) begin
      c_start = '0;
      r_start = (row == ROW_LAST) ? row : row + ROW_W'(1);
    end
  end

  assign rev_now = cfg.color_high < cfg.color_low;
  assign d = rev_now ? cfg.color_low - cfg.color_high : cfg.color_high - cfg.color_low;
  assign num = NUM_W'(samples.sample[WM_W-1:0] * d)
             + (rev_now ? NUM_W'(cfg.window_max) - NUM_W'(1) : '0);
  assign shifted = NUM_W'(cfg.window_max) << k;

  always_comb begin
    if (sat_lo) cur = cfg.color_low;
    else if (sat_hi) cur = cfg.color_high;
    else if (rev) cur = cfg.color_low - quo;
    else cur = cfg.color_low + quo;
  end

  assign c_inc = {1'b0, c_q} + WIDTH_W'(1);

  assign push.valid           = state == F_PUSH;
  assign push.data.row        = r_q;
  assign push.data.col        = c_q;
  assign push.data.cur        = cur;
  assign push.data.left       = left_lvl;
  assign push.data.up         = up;
  assign push.data.upper_left = ul_lvl;

  wmbz_ram #(.WIDTH(LVL_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (fire),
    .waddr (c_q),
    .wdata (cur),
    .raddr (c_q),
    .rdata (up)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      col      <= '0;
      row      <= '0;
      left_lvl <= '0;
      ul_lvl   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            c_q    <= c_start;
            r_q    <= r_start;
            sat_lo <= samples.sample[SMP_W-1] || samples.sample == '0;
            sat_hi <= {1'b0, samples.sample[WM_W-1:0]} >= {1'b0, cfg.window_max};
            rev    <= rev_now;
            rem    <= num;
            quo    <= '0;
            k      <= 3'd7;
            state  <= F_DIV;
          end
        end
        F_DIV: begin
          if (rem >= shifted) begin
            rem    <= rem - shifted;
            quo[k] <= 1'b1;
          end
          if (k == '0) state <= F_PUSH;
          else k <= k - 3'd1;
        end
        F_PUSH: begin
          if (fire) begin
            left_lvl <= cur;
            ul_lvl   <= up;
            if (c_inc >= cfg.width) begin
              col <= '0;
              row <= (r_q == ROW_LAST) ? r_q : r_q + ROW_W'(1);
            end else begin
              col <= c_inc[COL_W-1:0];
              row <= r_q;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/wmbz_back.sv
// wmbz_back: per-sample horizontal and vertical interpolation and pixel
// emission; depends on wmbz_pkg, wmbz_if
module wmbz_back (
  input  logic            clk,
  input  logic            rst,
  input  wmbz_pkg::cfg_t  cfg,
  input  logic            not_empty,
  input  wmbz_pkg::qent_t head,
  output logic            pop,
  wmbz_out_if.source      pixels
);
  import wmbz_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_HC, B_HU, B_HS, B_COL, B_VD, B_VS, B_EMIT} bstate_t;

  localparam int MAG_W  = 2 * LVL_W;
  localparam int PROD_W = MAG_W + RECIP_W;

  bstate_t                  state;
  qent_t                    e;
  logic [ZOOM_W-1:0]        i_ctr;
  logic [ZOOM_W-1:0]        j_ctr;
  logic [PROD_W-1:0]        prod;
  logic                     neg;
  logic signed [STEP_W-1:0] step_c;
  logic signed [STEP_W-1:0] step_u;
  logic [LVL_W-1:0]         hc_v;
  logic [LVL_W-1:0]         ht_v;
  logic [LVL_W-1:0]         hc_a [MAX_ZOOM];
  logic [LVL_W-1:0]         ht_a [MAX_ZOOM];
  logic signed [STEP_W-1:0] vs_a [MAX_ZOOM];

  logic [ZOOM_W-1:0]        z;
  logic [ZOOM_W-1:0]        ilo;
  logic [ZOOM_W-1:0]        jlo;
  logic [LVL_W-1:0]         op_a;
  logic [LVL_W-1:0]         op_b;
  logic [LVL_W-1:0]         mag;
  logic signed [STEP_W-1:0] quot;
  logic [2:0]               idx;
  logic                     out_free;
  logic [COORD_W:0]         row_base;
  logic [COORD_W:0]         col_base;
  logic                     run_end;

  assign z   = cfg.zoom;
  assign ilo = (e.col != '0) ? ZOOM_W'(1) : z;
  assign jlo = (e.row != '0) ? ZOOM_W'(1) : z;
  assign idx = 3'(i_ctr - ZOOM_W'(1));
  assign pop = state == B_IDLE && not_empty;
  assign out_free = !pixels.valid || pixels.ready;
  assign row_base = (COORD_W+1)'(e.row * z);
  assign col_base = (COORD_W+1)'(e.col * z);
  assign run_end  = i_ctr == z && j_ctr == z;

  always_comb begin
    unique case (state)
      B_HC:    begin op_a = e.left;       op_b = e.cur; end
      B_HU:    begin op_a = e.upper_left; op_b = e.up;  end
      default: begin op_a = ht_v;         op_b = hc_v;  end
    endcase
  end

  assign mag  = (op_b >= op_a) ? op_b - op_a : op_a - op_b;
  assign quot = neg ? -$signed({1'b0, prod[RECIP_SHIFT+STEP_W-2:RECIP_SHIFT]})
                    :  $signed({1'b0, prod[RECIP_SHIFT+STEP_W-2:RECIP_SHIFT]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      pixels.valid <= 1'b0;
    end else begin
      if (pixels.ready && state != B_EMIT) pixels.valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (not_empty) begin
            e     <= head;
            state <= B_HC;
          end
        end
        B_HC, B_HU, B_VD: begin
          prod <= PROD_W'({mag, LVL_W'(0)} * recip(z));
          neg  <= op_a > op_b;
          if (state == B_HU) step_c <= quot;
          unique case (state)
            B_HC:    state <= B_HU;
            B_HU:    state <= B_HS;
            default: state <= B_VS;
          endcase
          if (state == B_HC) i_ctr <= ilo;
        end
        B_HS: begin
          step_u <= quot;
          state  <= B_COL;
        end
        B_COL: begin
          hc_v  <= (i_ctr == z) ? e.cur : interp_val(e.left, step_c, i_ctr);
          ht_v  <= (i_ctr == z) ? e.up : interp_val(e.upper_left, step_u, i_ctr);
          state <= B_VD;
        end
        B_VS: begin
          hc_a[idx] <= hc_v;
          ht_a[idx] <= ht_v;
          vs_a[idx] <= quot;
          if (i_ctr == z) begin
            i_ctr <= ilo;
            j_ctr <= jlo;
            state <= B_EMIT;
          end else begin
            i_ctr <= i_ctr + ZOOM_W'(1);
            state <= B_COL;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            pixels.valid       <= 1'b1;
            pixels.out_row     <= COORD_W'(row_base + (COORD_W+1)'(j_ctr)
                                           - (COORD_W+1)'(z));
            pixels.out_col     <= COORD_W'(col_base + (COORD_W+1)'(i_ctr)
                                           - (COORD_W+1)'(z));
            pixels.pixel       <= (j_ctr == z) ? hc_a[idx]
                                  : interp_val(ht_a[idx], vs_a[idx], j_ctr);
            pixels.last_of_run <= run_end;
            if (run_end) begin
              state <= B_IDLE;
            end else if (i_ctr == z) begin
              i_ctr <= ilo;
              j_ctr <= j_ctr + ZOOM_W'(1);
            end else begin
              i_ctr <= i_ctr + ZOOM_W'(1);
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/window_map_bilinear_zoom.sv
// window_map_bilinear_zoom: top level, config registers, front, queue, back
// depends on wmbz_pkg, wmbz_if, wmbz_front, wmbz_queue, wmbz_back
//
//   channel   dir  payload                                  handshake
//   samples   in   sample[15:0] signed, plane_start         valid/ready
//   pixels    out  out_row[10:0] out_col[10:0] pixel[7:0]   valid/ready
//                  last_of_run
//   cfg       in   cfg_index[2:0] cfg_data[14:0]             cfg_we
//
// front: accept, 8-step bit-serial divide, line store write, sample by sample
// back: shared reciprocal multiplier does two step quotients plus one per
// emitted column, then one pixel a cycle while the pixel output is not stalled
// a 2-entry queue lets the front take new samples while the back emits
// rst is synchronous; line store content is undefined until written
module window_map_bilinear_zoom (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wmbz_pkg::IDX_W-1:0] cfg_index,
  input  logic [wmbz_pkg::CFG_W-1:0] cfg_data,
  wmbz_in_if.sink                    samples,
  wmbz_out_if.source                 pixels
);
  import wmbz_pkg::*;

  logic [WM_W-1:0]    window_max;
  logic [LVL_W-1:0]   color_low;
  logic [LVL_W-1:0]   color_high;
  logic [ZOOM_W-1:0]  zoom;
  logic [WIDTH_W-1:0] plane_width;
  cfg_t               cfg;
  qpush_t             q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_not_empty;
  qent_t              q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max  <= WM_W'(32767);
      color_low   <= '0;
      color_high  <= LVL_W'(255);
      zoom        <= ZOOM_W'(1);
      plane_width <= WIDTH_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_MAX:  window_max  <= cfg_data[WM_W-1:0];
        REG_COLOR_LOW:   color_low   <= cfg_data[LVL_W-1:0];
        REG_COLOR_HIGH:  color_high  <= cfg_data[LVL_W-1:0];
        REG_ZOOM:        zoom        <= cfg_data[ZOOM_W-1:0];
        REG_PLANE_WIDTH: plane_width <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.window_max = window_max;
  assign cfg.color_low  = color_low;
  assign cfg.color_high = color_high;
  assign cfg.zoom       = clamp_zoom(zoom);
  assign cfg.width      = clamp_width(plane_width);

  wmbz_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .push    (q_push),
    .full    (q_full)
  );

  wmbz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wmbz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (q_pop),
    .pixels    (pixels)
  );

  a_zoom_range: assert property (@(posedge clk) disable iff (rst)
    cfg.zoom >= ZOOM_W'(1) && cfg.zoom <= ZOOM_W'(MAX_ZOOM))
    else $error("effective zoom out of range");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    cfg.width >= WIDTH_W'(1) && cfg.width <= WIDTH_W'(MAX_WIDTH))
    else $error("effective width out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("front took a second sample while dividing");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("back popped an empty queue");
endmodule

// File: verif/wmbz_checker.sv
// wmbz_checker: watches the sample, pixel and config channels, predicts the zoomed pixels
// of every accepted sample request and compares them in order; depends on wmbz_pkg, wmbz_if
`timescale 1ns / 100ps
module wmbz_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  wmbz_in_if          samples,
  wmbz_out_if         pixels,
  output int          errors,
  output int          pending,
  output int          n_samples,
  output int          n_pixels,
  output int          next_row,
  output int          next_col,
  output logic [255:0] seen_cols
);
  import wmbz_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LVL_W-1:0]   pixel;
    logic               last;
  } zpix_t;

  zpix_t pix_q[$];
  int win_max, clr_lo, clr_hi, zm, wd;
  int line_lvl[MAX_WIDTH];
  int left_lvl, upleft_lvl;

  assign pending = pix_q.size();

  function automatic int blend(int a, int b, int i, int z);
    int step, v;
    if (i == 0) return a;
    if (i >= z) return b;
    step = ((b - a) * 256) / z;
    v = a * 256 + 128 + i * step;
    if (v < 0) v = 0;
    return (v / 256) & 255;
  endfunction

  function automatic int window_level(logic signed [SMP_W-1:0] s);
    int sv;
    sv = s;
    if (sv <= 0) return clr_lo;
    if (sv >= win_max) return clr_hi;
    if (clr_hi >= clr_lo) return (clr_lo + (sv * (clr_hi - clr_lo)) / win_max) & 255;
    return (clr_lo - (sv * (clr_lo - clr_hi) + win_max - 1) / win_max) & 255;
  endfunction

  task automatic predict_block(logic signed [SMP_W-1:0] s, logic ps);
    int z, w, r, c, cur, up, jlo, ilo, hc, ht, v;
    zpix_t p;
    z = (zm == 0) ? 1 : (zm > MAX_ZOOM ? MAX_ZOOM : zm);
    w = (wd == 0) ? 1 : (wd > MAX_WIDTH ? MAX_WIDTH : wd);
    if (ps) begin
      next_col = 0;
      next_row = 0;
    end else if (next_col >= w) begin
      next_col = 0;
      if (next_row < MAX_HEIGHT - 1) next_row++;
    end
    r = next_row;
    c = next_col;
    cur = window_level(s);
    up = line_lvl[c];
    jlo = (r > 0) ? 1 : z;
    ilo = (c > 0) ? 1 : z;
    for (int j = jlo; j <= z; j++) begin
      for (int i = ilo; i <= z; i++) begin
        hc = (c > 0) ? blend(left_lvl, cur, i, z) : cur;
        v = hc;
        if (j < z) begin
          ht = (c > 0) ? blend(upleft_lvl, up, i, z) : up;
          v = blend(ht, hc, j, z);
        end
        p.row = COORD_W'(r * z + j - z);
        p.col = COORD_W'(c * z + i - z);
        p.pixel = LVL_W'(v);
        p.last = (j == z) && (i == z);
        pix_q.push_back(p);
      end
    end
    upleft_lvl = up;
    line_lvl[c] = cur;
    seen_cols[c] = 1'b1;
    left_lvl = cur;
    if (c + 1 >= w) begin
      next_col = 0;
      if (next_row < MAX_HEIGHT - 1) next_row++;
    end else begin
      next_col = c + 1;
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    n_samples = 0;
    n_pixels = 0;
  end

  always @(posedge clk) begin
    zpix_t e;
    if (rst) begin
      win_max = 32767; clr_lo = 0; clr_hi = 255; zm = 1; wd = 256;
      left_lvl = 0; upleft_lvl = 0; next_row = 0; next_col = 0;
      seen_cols = '0;
      foreach (line_lvl[k]) line_lvl[k] = 0;
      pix_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_MAX:  win_max = cfg_data;
          REG_COLOR_LOW:   clr_lo = cfg_data[7:0];
          REG_COLOR_HIGH:  clr_hi = cfg_data[7:0];
          REG_ZOOM:        zm = cfg_data[3:0];
          REG_PLANE_WIDTH: wd = cfg_data[8:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) begin
        n_pixels++;
        if (pix_q.size() == 0) begin
          report("unexpected pixel row", pixels.out_row, -1);
        end else begin
          e = pix_q.pop_front();
          if (pixels.out_row !== e.row) report("out_row", pixels.out_row, e.row);
          if (pixels.out_col !== e.col) report("out_col", pixels.out_col, e.col);
          if (pixels.pixel !== e.pixel) report("pixel", pixels.pixel, e.pixel);
          if (pixels.last_of_run !== e.last) report("last_of_run", pixels.last_of_run, e.last);
        end
      end
      if (samples.valid && samples.ready) begin
        n_samples++;
        predict_block(samples.sample, samples.plane_start);
      end
    end
  end
endmodule

// File: verif/tb_top.sv
// tb_top: clock, reset, config phases and sample/pixel traffic for window_map_bilinear_zoom
// depends on wmbz_pkg, wmbz_if, wmbz_checker and the block itself
`timescale 1ns / 100ps
module tb_top;
  import wmbz_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  logic        hold_req = 1'b0;
  int errors, pending, n_samples, n_pixels, next_row, next_col;
  logic [255:0] seen_cols;
  int cur_wm, cur_width, idle_cycles;

  wmbz_in_if  smp();
  wmbz_out_if pix();

  window_map_bilinear_zoom dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(smp.sink), .pixels(pix.source)
  );

  wmbz_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(smp), .pixels(pix), .errors(errors), .pending(pending),
    .n_samples(n_samples), .n_pixels(n_pixels), .next_row(next_row), .next_col(next_col),
    .seen_cols(seen_cols)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    smp.valid = 1'b0;
    smp.sample = '0;
    smp.plane_start = 1'b0;
    pix.ready = 1'b0;
  end

  always @(posedge clk) begin
    in_acc <= smp.valid && smp.ready;
    out_acc <= pix.valid && pix.ready;
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (pix.valid && pix.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 6000) begin
      $display("watchdog expired with %0d pixels outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // pixel receiver with random stalls and one long hold-off
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pix.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        pix.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix.ready <= 1'b1;
      do @(negedge clk); while (!out_acc && !hold_req);
    end
  end

  task automatic set_regs(int wm, int lo, int hi, int z, int w);
    int vals[5];
    vals = '{wm, lo, hi, z, w};
    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[2:0];
      cfg_data <= vals[k][14:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_wm = wm;
    cur_width = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
  endtask

  task automatic send_sample(logic [15:0] s, logic ps, int gap);
    int r, c;
    r = next_row;
    c = next_col;
    if (c >= cur_width) begin
      c = 0;
      if (r < MAX_HEIGHT - 1) r++;
    end
    if (ps) begin
      r = 0;
      c = 0;
    end
    // never let a row above zero read an unwritten line store column
    if (r > 0 && !seen_cols[c]) ps = 1'b1;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample <= s;
    smp.plane_start <= ps;
    do @(negedge clk); while (!in_acc);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1, 2: return 16'($urandom_range(0, (cur_wm == 0) ? 40 : cur_wm + 1));
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h0000;
          2: return 16'h0001;
          3: return 16'(cur_wm);
          4: return 16'(cur_wm - 1);
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  task automatic run_random(int n, int start_odds);
    for (int k = 0; k < n; k++) begin
      send_sample(pick_sample(), (k == 0) || ($urandom_range(0, start_odds) == 0),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8));
    end
  endtask

  initial begin
    logic [15:0] edge_smp[8];
    edge_smp = '{16'h8000, 16'h0000, 16'h0001, 16'h7FFF, 16'h7FFE, 16'hFFFF, 16'h5555, 16'hAAAA};
    cur_wm = 32767;
    cur_width = 256;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values, field extremes
    foreach (edge_smp[k]) send_sample(edge_smp[k], k == 0, 0);
    // zero window, zoom max, narrow plane: second row interpolates
    set_regs(0, 10, 200, 8, 3);
    for (int k = 0; k < 7; k++) send_sample(edge_smp[k], k == 0, k % 2);
    // reversed colors, odd zoom
    set_regs(1000, 250, 5, 3, 4);
    for (int k = 0; k < 8; k++) send_sample(16'(k * 150 - 100), k == 0, 0);
    // narrower width set after the row wrapped; zoom 0 and width 0 clamp
    set_regs(1000, 250, 5, 0, 2);
    send_sample(16'd500, 1'b0, 0);
    set_regs(32767, 0, 255, 15, 0);
    send_sample(16'd300, 1'b1, 0);
    send_sample(16'd20000, 1'b0, 0);

    // random settings with random content
    for (int p = 0; p < 6; p++) begin
      set_regs((p == 0) ? 32767 : $urandom_range(0, 32767), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 9), $urandom_range(0, 300));
      if (p == 2) hold_req = 1'b1;
      run_random(12, 15);
    end
    // wide row at small zoom
    set_regs(5000, 255, 0, 2, 256);
    run_random(20, 200);
    // one column, max zoom, enough rows to saturate the row count
    set_regs(20000, 3, 250, 8, 1);
    run_random(262, 100000);

    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("ran %0d sample requests and checked %0d pixels", n_samples, n_pixels);
    $display("covered clamps, reversed colors, width shrink, backpressure, row saturation");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/wmbz_pkg.sv
hdl/wmbz_if.sv
hdl/wmbz_ram.sv
hdl/wmbz_queue.sv
hdl/wmbz_front.sv
hdl/wmbz_back.sv
hdl/window_map_bilinear_zoom.sv
verif/wmbz_checker.sv
verif/tb_top.sv
